[hw/rtl/rhh_pkg.sv]
// shared types, codes and helpers of the robin hood hash set
// no dependencies
package rhh_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned SlotW      = 8;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned HashW      = 32;
  localparam int unsigned SizeW      = 9;
  localparam int unsigned NumW       = HashW + 1;

  localparam logic [1:0] KindInsert   = 2'd0;
  localparam logic [1:0] KindRemove   = 2'd1;
  localparam logic [1:0] KindContains = 2'd2;

  localparam logic [1:0] TagEmpty = 2'd0;
  localparam logic [1:0] TagLive  = 2'd1;
  localparam logic [1:0] TagTomb  = 2'd2;

  localparam logic [2:0] StInserted  = 3'd0;
  localparam logic [2:0] StPresent   = 3'd1;
  localparam logic [2:0] StRemoved   = 3'd2;
  localparam logic [2:0] StNotFound  = 3'd3;
  localparam logic [2:0] StFound     = 3'd4;
  localparam logic [2:0] StLoadLimit = 3'd5;
  localparam logic [2:0] StTombs     = 3'd6;

  typedef struct packed {
    logic [1:0]       tag;
    logic [SizeW-1:0] probes;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
  } entry_t;

  function automatic logic [SizeW-1:0] eff_size(logic [SizeW-1:0] ts);
    logic [SizeW-1:0] r;
    r = ts;
    if (ts == '0) r = SizeW'(1);
    else if (ts > SizeW'(TableDepth)) r = SizeW'(TableDepth);
    return r;
  endfunction

  // value below 3*s reduced modulo s
  function automatic logic [SizeW-1:0] red3(logic [SizeW:0] v, logic [SizeW-1:0] s);
    logic [SizeW:0] t;
    t = v;
    if (t >= {1'b0, s}) t = t - {1'b0, s};
    if (t >= {1'b0, s}) t = t - {1'b0, s};
    if (t >= {1'b0, s}) t = t - {1'b0, s};
    return t[SizeW-1:0];
  endfunction

endpackage

[hw/rtl/robin_hood_hash_set_core.sv]
// top level of the robin hood hash set: control, slot memory, result register
// depends on rhh_pkg and rhh_mod
//
// One word in gives one word out. An operation first reduces the hash modulo the table size,
// then walks the quadratic probe sequence, bounded by the table size, alternating a slot read
// and its evaluation, as the slot memory has a registered read. Every Robin Hood eviction
// takes a multiply and a further modulo pass to resume the probe sequence of the evicted key
// at its stored probe count. An insert writes into a second bank of the slot memory and flips
// per-slot bank selects when it succeeds, so a refused insert leaves the table untouched. Slot
// tags start empty by per-slot valid bits; no clearing pass is needed after reset.
module robin_hood_hash_set_core import rhh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // key, hash
  input  logic [1:0]  s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // key_out, count, zero fill
  output logic [2:0]  m_axis_tuser_o   // status
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SLDiv  = 4'd1;
  localparam logic [3:0] SLRd   = 4'd2;
  localparam logic [3:0] SLEv   = 4'd3;
  localparam logic [3:0] SRes   = 4'd4;
  localparam logic [3:0] SWRd   = 4'd5;
  localparam logic [3:0] SWEv   = 4'd6;
  localparam logic [3:0] SWMul  = 4'd7;
  localparam logic [3:0] SWDst  = 4'd8;
  localparam logic [3:0] SWDiv  = 4'd9;
  localparam logic [3:0] SFin   = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [SizeW-1:0]      tsize_q;
  logic [SizeW-1:0]      s_eff, half;
  logic [1:0]            kind_q, kind_d;
  logic [KeyW-1:0]       key_q, key_d, ck_q, ck_d;
  logic [HashW-1:0]      hash_q, hash_d, ch_q, ch_d;
  logic [SizeW-1:0]      cp_q, cp_d, tombs_q, tombs_d, ftp_q, ftp_d, lp_q, lp_d;
  logic [SlotW-1:0]      ft_q, ft_d, idx_q, idx_d, base_q, base_d, rd_slot_q, rd_slot_d;
  logic [SizeW-1:0]      inc_q, inc_d;
  logic                  ft_vld_q, ft_vld_d, found_q, found_d, rd_bank_q, rd_bank_d;
  logic [2*SizeW-1:0]    sq_q, sq_d;
  logic [SizeW-1:0]      count_q, count_d;
  logic [TableDepth-1:0] cur_q, cur_d, dirty_q, dirty_d, vld0_q, vld0_d;
  logic [2:0]            res_st_q, res_st_d;
  logic [KeyW-1:0]       res_key_q, res_key_d;
  logic                  mv_q, mv_d;
  logic [2:0]            mst_q;
  logic [KeyW-1:0]       mkey_q;
  logic [SizeW-1:0]      mcnt_q;

  entry_t                mem [2*TableDepth];
  entry_t                rdata_q, wdata;
  logic                  ram_re, ram_we;
  logic [SlotW:0]        raddr, waddr;

  logic                  div_start, div_done;
  logic [NumW-1:0]       div_num;
  logic [SizeW-1:0]      div_rem;

  logic [1:0]            rd_tag;
  logic                  rd_vld;
  logic [SizeW:0]        adv_sum;
  logic [SizeW-1:0]      adv_idx, adv_inc, inc0;
  logic                  out_free;

  rhh_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_eff),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign s_eff    = eff_size(tsize_q);
  assign half     = s_eff >> 1;
  assign inc0     = (s_eff == SizeW'(1)) ? '0 : SizeW'(1);
  // the second bank of a slot is only read after it was written
  assign rd_vld   = rd_bank_q ? 1'b1 : vld0_q[rd_slot_q];
  assign rd_tag   = rd_vld ? rdata_q.tag : TagEmpty;
  assign adv_sum  = {2'b00, idx_q} + {1'b0, inc_q};
  assign adv_idx  = red3(adv_sum, s_eff);
  assign adv_inc  = red3({1'b0, inc_q} + (SizeW+1)'(2), s_eff);
  assign out_free = !mv_q || m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    key_d     = key_q;
    hash_d    = hash_q;
    ck_d      = ck_q;
    ch_d      = ch_q;
    cp_d      = cp_q;
    tombs_d   = tombs_q;
    ftp_d     = ftp_q;
    ft_d      = ft_q;
    ft_vld_d  = ft_vld_q;
    lp_d      = lp_q;
    idx_d     = idx_q;
    inc_d     = inc_q;
    base_d    = base_q;
    found_d   = found_q;
    rd_slot_d = rd_slot_q;
    rd_bank_d = rd_bank_q;
    sq_d      = sq_q;
    count_d   = count_q;
    cur_d     = cur_q;
    dirty_d   = dirty_q;
    vld0_d    = vld0_q;
    res_st_d  = res_st_q;
    res_key_d = res_key_q;
    mv_d      = mv_q && !m_axis_tready_i;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    raddr     = '0;
    waddr     = '0;
    wdata     = rdata_q;
    div_start = 1'b0;
    div_num   = {1'b0, s_axis_tdata_i[63:32]};

    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid_i) begin
          kind_d    = s_axis_tuser_i;
          key_d     = s_axis_tdata_i[31:0];
          hash_d    = s_axis_tdata_i[63:32];
          res_key_d = '0;
          if (s_axis_tuser_i == KindInsert || s_axis_tuser_i == KindRemove ||
              s_axis_tuser_i == KindContains) begin
            div_start = 1'b1;
            state_d   = SLDiv;
          end else begin
            res_st_d = StNotFound;
            state_d  = SFin;
          end
        end
      end
      SLDiv: begin
        if (div_done) begin
          base_d  = div_rem[SlotW-1:0];
          idx_d   = div_rem[SlotW-1:0];
          inc_d   = inc0;
          lp_d    = '0;
          state_d = SLRd;
        end
      end
      SLRd: begin
        if (lp_q >= s_eff) begin
          found_d = 1'b0;
          state_d = SRes;
        end else begin
          ram_re    = 1'b1;
          raddr     = {cur_q[idx_q], idx_q};
          rd_slot_d = idx_q;
          rd_bank_d = cur_q[idx_q];
          state_d   = SLEv;
        end
      end
      SLEv: begin
        if (rd_tag == TagEmpty) begin
          found_d = 1'b0;
          state_d = SRes;
        end else if (rd_tag == TagLive && rdata_q.hash == hash_q && rdata_q.key == key_q) begin
          found_d = 1'b1;
          state_d = SRes;
        end else begin
          lp_d    = lp_q + SizeW'(1);
          idx_d   = adv_idx[SlotW-1:0];
          inc_d   = adv_inc;
          state_d = SLRd;
        end
      end
      SRes: begin
        state_d = SFin;
        case (kind_q)
          KindContains: res_st_d = found_q ? StFound : StNotFound;
          KindRemove: begin
            if (found_q) begin
              ram_we    = 1'b1;
              waddr     = {rd_bank_q, rd_slot_q};
              wdata.tag = TagTomb;
              res_key_d = rdata_q.key;
              res_st_d  = StRemoved;
              if (count_q != '0) count_d = count_q - SizeW'(1);
            end else begin
              res_st_d = StNotFound;
            end
          end
          default: begin
            if (found_q) begin
              res_st_d = StPresent;
            end else if (count_q > half) begin
              res_st_d = StLoadLimit;
            end else begin
              ck_d     = key_q;
              ch_d     = hash_q;
              cp_d     = '0;
              tombs_d  = '0;
              ft_vld_d = 1'b0;
              idx_d    = base_q;
              inc_d    = inc0;
              state_d  = SWRd;
            end
          end
        endcase
      end
      SWRd: begin
        if (cp_q >= s_eff) begin
          state_d = SFin;
          if (!ft_vld_q) begin
            res_st_d = StLoadLimit;
            dirty_d  = '0;
          end else begin
            ram_we      = 1'b1;
            waddr       = {~cur_q[ft_q], ft_q};
            wdata       = '{tag: TagLive, probes: ftp_q, key: ck_q, hash: ch_q};
            dirty_d[ft_q] = 1'b1;
            cur_d       = cur_q ^ dirty_d;
            dirty_d     = '0;
            count_d     = count_q + SizeW'(1);
            res_st_d    = StInserted;
          end
        end else begin
          ram_re    = 1'b1;
          rd_bank_d = dirty_q[idx_q] ? ~cur_q[idx_q] : cur_q[idx_q];
          raddr     = {rd_bank_d, idx_q};
          rd_slot_d = idx_q;
          cp_d      = cp_q + SizeW'(1);
          state_d   = SWEv;
        end
      end
      SWEv: begin
        if (rd_tag == TagEmpty) begin
          ram_we = 1'b1;
          if (ft_vld_q) begin
            waddr       = {~cur_q[ft_q], ft_q};
            wdata       = '{tag: TagLive, probes: ftp_q, key: ck_q, hash: ch_q};
            dirty_d[ft_q] = 1'b1;
          end else begin
            waddr       = {~cur_q[rd_slot_q], rd_slot_q};
            wdata       = '{tag: TagLive, probes: cp_q, key: ck_q, hash: ch_q};
            dirty_d[rd_slot_q] = 1'b1;
          end
          cur_d    = cur_q ^ dirty_d;
          dirty_d  = '0;
          count_d  = count_q + SizeW'(1);
          res_st_d = StInserted;
          state_d  = SFin;
        end else if (rd_tag != TagLive) begin
          tombs_d = tombs_q + SizeW'(1);
          if (tombs_d > half) begin
            dirty_d  = '0;
            res_st_d = StTombs;
            state_d  = SFin;
          end else begin
            if (!ft_vld_q) begin
              ft_vld_d = 1'b1;
              ft_d     = rd_slot_q;
              ftp_d    = cp_q;
            end
            idx_d   = adv_idx[SlotW-1:0];
            inc_d   = adv_inc;
            state_d = SWRd;
          end
        end else if (rdata_q.probes < cp_q) begin
          ram_we   = 1'b1;
          waddr    = {~cur_q[rd_slot_q], rd_slot_q};
          wdata    = '{tag: TagLive, probes: cp_q, key: ck_q, hash: ch_q};
          dirty_d[rd_slot_q] = 1'b1;
          ck_d     = rdata_q.key;
          ch_d     = rdata_q.hash;
          cp_d     = rdata_q.probes;
          ft_vld_d = 1'b0;
          ftp_d    = '0;
          state_d  = SWMul;
        end else begin
          idx_d   = adv_idx[SlotW-1:0];
          inc_d   = adv_inc;
          state_d = SWRd;
        end
      end
      SWMul: begin
        sq_d    = cp_q * cp_q;
        state_d = SWDst;
      end
      SWDst: begin
        div_start = 1'b1;
        div_num   = {1'b0, ch_q} + {{(NumW-2*SizeW){1'b0}}, sq_q};
        state_d   = SWDiv;
      end
      SWDiv: begin
        if (div_done) begin
          idx_d   = div_rem[SlotW-1:0];
          inc_d   = red3({cp_q, 1'b1}, s_eff);
          state_d = SWRd;
        end
      end
      SFin: begin
        if (out_free) begin
          mv_d    = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    if (ram_we && !waddr[SlotW]) vld0_d[waddr[SlotW-1:0]] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      tsize_q  <= SizeW'(255);
      count_q  <= '0;
      cur_q    <= '0;
      dirty_q  <= '0;
      vld0_q   <= '0;
      mv_q     <= 1'b0;
      ft_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) tsize_q <= cfg_wdata_i;
      count_q  <= count_d;
      cur_q    <= cur_d;
      dirty_q  <= dirty_d;
      vld0_q   <= vld0_d;
      mv_q     <= mv_d;
      ft_vld_q <= ft_vld_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    key_q     <= key_d;
    hash_q    <= hash_d;
    ck_q      <= ck_d;
    ch_q      <= ch_d;
    cp_q      <= cp_d;
    tombs_q   <= tombs_d;
    ftp_q     <= ftp_d;
    ft_q      <= ft_d;
    lp_q      <= lp_d;
    idx_q     <= idx_d;
    inc_q     <= inc_d;
    base_q    <= base_d;
    rd_slot_q <= rd_slot_d;
    rd_bank_q <= rd_bank_d;
    sq_q      <= sq_d;
    res_st_q  <= res_st_d;
    res_key_q <= res_key_d;
    if (state_q == SFin && out_free) begin
      mst_q  <= res_st_q;
      mkey_q <= res_key_q;
      mcnt_q <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) mem[waddr] <= wdata;
    if (ram_re) rdata_q <= mem[raddr];
  end

  assign s_axis_tready_o = (state_q == SIdle);
  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tuser_o  = mst_q;
  assign m_axis_tdata_o  = {7'd0, mcnt_q, mkey_q};

endmodule

[hw/rtl/rhh_mod.sv]
// iterative modulo unit, two quotient bits per cycle
// depends on rhh_pkg
module rhh_mod import rhh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [SizeW-1:0] den_i,
  output logic             done_o,
  output logic [SizeW-1:0] rem_o
);

  localparam int unsigned ShW   = NumW + 1;
  localparam int unsigned Steps = ShW / 2;

  logic [ShW-1:0]   sh_q, sh_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [SizeW:0]   t1, t2;

  always_comb begin
    t1 = {rem_q, sh_q[ShW-1]};
    if (t1 >= {1'b0, den_i}) t1 = t1 - {1'b0, den_i};
    t2 = {t1[SizeW-1:0], sh_q[ShW-2]};
    if (t2 >= {1'b0, den_i}) t2 = t2 - {1'b0, den_i};
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      sh_d   = {1'b0, num_i};
      rem_d  = '0;
      cnt_d  = 5'(Steps);
      busy_d = 1'b1;
    end else if (busy_q && cnt_q != '0) begin
      sh_d  = {sh_q[ShW-3:0], 2'b00};
      rem_d = t2[SizeW-1:0];
      cnt_d = cnt_q - 5'd1;
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

[hw/rtl/rhh_chk.sv]
// port-level checks of the robin hood hash set, bound to the top level
// depends on rhh_pkg and robin_hood_hash_set_core
module rhh_chk import rhh_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= StTombs)
    else $error("status code out of range");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != StRemoved |-> m_axis_tdata_o[31:0] == '0)
    else $error("key returned without a remove");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[40:32] <= 9'(TableDepth))
    else $error("entry count above table depth");

endmodule

bind robin_hood_hash_set_core rhh_chk u_rhh_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
